FILE: src/ble_pkg.sv
// Shared widths, codes and control structs for the breathing LED envelope.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package ble_pkg;

   localparam int unsigned PERIOD_W   = 16;
   localparam int unsigned LEVEL_W    = 17;
   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned BEAT_W     = 16;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 17;

   // milliseconds per beat
   localparam int unsigned BEAT_MS = 10;

   // shared divider: 34-bit dividend, 17-bit divisor, one quotient bit a cycle
   localparam int unsigned DIV_W     = 34;
   localparam int unsigned DSR_W     = 17;
   localparam int unsigned DIV_STEPS = DIV_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [LEVEL_W-1:0] Q_ONE      = 17'd65536;
   localparam logic [15:0]        ROUND_HALF = 16'd32768;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_MS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LEVEL = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PHASE = 4'b0010,
      ST_TRI   = 4'b0100,
      ST_GAIN  = 4'b1000
   } state_type;

   typedef struct packed {
      logic load_phase;
      logic load_tri;
      logic div_step;
      logic load_gain;
      logic tick_add;
      logic pixel_load;
      logic csr_write;
   } cmd_type;

   typedef struct packed {
      logic period_zero;
   } sts_type;

endpackage

`default_nettype wire

FILE: src/ble_req_if.sv
// Input channel of the envelope: valid/ready plus one tick or pixel word.
// Depends on ble_pkg for field widths.
`default_nettype none

interface ble_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [ble_pkg::BEAT_W-1:0]    beat_count;
   logic [ble_pkg::CHAN_W-1:0]    red_in;
   logic [ble_pkg::CHAN_W-1:0]    green_in;
   logic [ble_pkg::CHAN_W-1:0]    blue_in;
   logic [ble_pkg::CHAN_W-1:0]    white_in;

   modport source (output valid, opcode, beat_count, red_in, green_in, blue_in, white_in,
                   input ready);
   modport sink   (input valid, opcode, beat_count, red_in, green_in, blue_in, white_in,
                   output ready);
endinterface

`default_nettype wire

FILE: src/ble_rsp_if.sv
// Result channel of the envelope: valid/ready plus one scaled RGBW word.
// Depends on ble_pkg for field widths.
`default_nettype none

interface ble_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ble_pkg::CHAN_W-1:0] red_out;
   logic [ble_pkg::CHAN_W-1:0] green_out;
   logic [ble_pkg::CHAN_W-1:0] blue_out;
   logic [ble_pkg::CHAN_W-1:0] white_out;

   modport source (output valid, red_out, green_out, blue_out, white_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, white_out, output ready);
endinterface

`default_nettype wire

FILE: src/ble_csr_if.sv
// Register write channel of the envelope: valid/ready, register index, data.
// Depends on ble_pkg for field widths.
`default_nettype none

interface ble_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ble_pkg::CSR_IDX_W-1:0]  index;
   logic [ble_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/breathing_led_envelope.sv
// Top level of the breathing LED envelope: controller plus datapath.
// Depends on ble_pkg, ble_req_if, ble_rsp_if, ble_csr_if, ble_ctrl, ble_datapath.
//
//   channel   dir  word
//   req_chan  in   opcode, beat_count, red_in, green_in, blue_in, white_in
//   rsp_chan  out  red_out, green_out, blue_out, white_out
//   csr_chan  in   index (0 period_ms, 1 min_level), data
//
// A pixel word is scaled into the result register; pixels stream one per cycle unless a
// result is held or a recompute runs. A tick, a register write and reset each start a
// gain recompute with req_chan.ready low: phase load, 34 divider steps, triangle load,
// 34 divider steps, a turnaround and the gain multiply (only the multiply with a zero period).
// A register write during a recompute forces another pass once it ends.
// A held result blocks the next word of either kind; csr_chan is always ready.
`default_nettype none

module breathing_led_envelope (
   input wire logic  clock,
   input wire logic  reset,
   ble_req_if.sink   req_chan,
   ble_rsp_if.source rsp_chan,
   ble_csr_if.sink   csr_chan
);

   ble_pkg::cmd_type cmd;
   ble_pkg::sts_type sts;

   ble_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .csr_valid  (csr_chan.valid),
      .csr_ready  (csr_chan.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ble_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .beat_count (req_chan.beat_count),
      .red_in     (req_chan.red_in),
      .green_in   (req_chan.green_in),
      .blue_in    (req_chan.blue_in),
      .white_in   (req_chan.white_in),
      .csr_index  (csr_chan.index),
      .csr_data   (csr_chan.data),
      .red_out    (rsp_chan.red_out),
      .green_out  (rsp_chan.green_out),
      .blue_out   (rsp_chan.blue_out),
      .white_out  (rsp_chan.white_out)
   );

   // a result appears only after a pixel word was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |->
         $past(req_chan.valid && req_chan.ready && (req_chan.opcode == ble_pkg::OP_PIXEL)))
      else $error("result without accepted pixel");

   // a tick invalidates the gain, so input must stall next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.opcode == ble_pkg::OP_TICK))
         |=> !req_chan.ready)
      else $error("input taken while gain stale");

   // divider and gain commands never overlap
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_phase, cmd.load_tri, cmd.div_step, cmd.load_gain}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: src/ble_datapath.sv
// Datapath: registers, beat total, shared restoring divider, gain and channel scaling.
// Depends on ble_pkg; driven by ble_ctrl through ble_pkg::cmd_type.
`default_nettype none

module ble_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire ble_pkg::cmd_type               cmd,
   output      ble_pkg::sts_type               sts,
   input  wire logic [ble_pkg::BEAT_W-1:0]     beat_count,
   input  wire logic [ble_pkg::CHAN_W-1:0]     red_in,
   input  wire logic [ble_pkg::CHAN_W-1:0]     green_in,
   input  wire logic [ble_pkg::CHAN_W-1:0]     blue_in,
   input  wire logic [ble_pkg::CHAN_W-1:0]     white_in,
   input  wire logic [ble_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ble_pkg::CSR_DATA_W-1:0] csr_data,
   output      logic [ble_pkg::CHAN_W-1:0]     red_out,
   output      logic [ble_pkg::CHAN_W-1:0]     green_out,
   output      logic [ble_pkg::CHAN_W-1:0]     blue_out,
   output      logic [ble_pkg::CHAN_W-1:0]     white_out
);

   logic [ble_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [ble_pkg::LEVEL_W-1:0]  min_ff, min_in;
   logic [ble_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [ble_pkg::DIV_W-1:0]    quo_ff, quo_in;
   logic [ble_pkg::DSR_W-1:0]    rem_ff, rem_in;
   logic [ble_pkg::DSR_W-1:0]    dsr_ff, dsr_in;
   logic [ble_pkg::LEVEL_W-1:0]  gain_ff, gain_in;
   logic [ble_pkg::CHAN_W-1:0]   red_ff, red_in_nx;
   logic [ble_pkg::CHAN_W-1:0]   green_ff, green_in_nx;
   logic [ble_pkg::CHAN_W-1:0]   blue_ff, blue_in_nx;
   logic [ble_pkg::CHAN_W-1:0]   white_ff, white_in_nx;

   logic [ble_pkg::TOTAL_W-1:0]  scaled_time;
   logic [ble_pkg::PERIOD_W-1:0] phase;
   logic [ble_pkg::PERIOD_W-1:0] num;
   logic [ble_pkg::DSR_W:0]      trial;
   logic                         trial_ge;
   logic [ble_pkg::LEVEL_W-1:0]  tri_val;
   logic [ble_pkg::LEVEL_W-1:0]  min_sat;
   logic [ble_pkg::LEVEL_W-1:0]  min_inv;
   logic [34:0]                  gain_sum;

   function automatic logic [ble_pkg::CHAN_W-1:0] scale_chan(
      input logic [ble_pkg::CHAN_W-1:0]  c,
      input logic [ble_pkg::LEVEL_W-1:0] g
   );
      logic [24:0] prod;
      prod = 25'(c) * 25'(g) + 25'(ble_pkg::ROUND_HALF);
      return prod[23:16];
   endfunction

   assign sts.period_zero = (period_ff == '0);

   // t = BEAT_MS * total, wrapped to 32 bits
   assign scaled_time = 32'(total_ff * 32'(ble_pkg::BEAT_MS));

   // fold the phase onto the rising half
   assign phase = rem_ff[ble_pkg::PERIOD_W-1:0];
   assign num   = ({phase, 1'b0} <= {1'b0, period_ff}) ? phase : period_ff - phase;

   assign trial    = {rem_ff, quo_ff[ble_pkg::DIV_W-1]};
   assign trial_ge = trial >= {1'b0, dsr_ff};

   assign tri_val = sts.period_zero ? '0 :
                    (quo_ff > ble_pkg::DIV_W'(ble_pkg::Q_ONE)) ? ble_pkg::Q_ONE :
                    quo_ff[ble_pkg::LEVEL_W-1:0];
   assign min_sat  = (min_ff > ble_pkg::Q_ONE) ? ble_pkg::Q_ONE : min_ff;
   assign min_inv  = ble_pkg::Q_ONE - min_sat;
   assign gain_sum = 35'(tri_val) * 35'(min_inv) + {2'b0, min_sat, 16'b0}
                     + 35'(ble_pkg::ROUND_HALF);

   always_comb begin
      period_in   = period_ff;
      min_in      = min_ff;
      total_in    = total_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      dsr_in      = dsr_ff;
      gain_in     = gain_ff;
      red_in_nx   = red_ff;
      green_in_nx = green_ff;
      blue_in_nx  = blue_ff;
      white_in_nx = white_ff;

      if (cmd.csr_write) begin
         case (csr_index)
            ble_pkg::REG_PERIOD_MS: period_in = csr_data[ble_pkg::PERIOD_W-1:0];
            ble_pkg::REG_MIN_LEVEL: min_in    = csr_data[ble_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end

      if (cmd.tick_add && !sts.period_zero) begin
         total_in = total_ff + ble_pkg::TOTAL_W'(beat_count);
      end

      if (cmd.load_phase) begin
         quo_in = ble_pkg::DIV_W'(scaled_time);
         rem_in = '0;
         dsr_in = ble_pkg::DSR_W'(period_ff);
      end else if (cmd.load_tri) begin
         // (4*num*2^16 + p) / (2p)
         quo_in = {num, 18'b0} + ble_pkg::DIV_W'(period_ff);
         rem_in = '0;
         dsr_in = {period_ff, 1'b0};
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[ble_pkg::DIV_W-2:0], trial_ge};
         rem_in = trial_ge ? ble_pkg::DSR_W'(trial - {1'b0, dsr_ff})
                           : trial[ble_pkg::DSR_W-1:0];
      end

      if (cmd.load_gain) begin
         gain_in = gain_sum[32:16];
      end

      if (cmd.pixel_load) begin
         red_in_nx   = scale_chan(red_in, gain_ff);
         green_in_nx = scale_chan(green_in, gain_ff);
         blue_in_nx  = scale_chan(blue_in, gain_ff);
         white_in_nx = scale_chan(white_in, gain_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd1000;
         min_ff    <= '0;
         total_ff  <= '0;
      end else begin
         period_ff <= period_in;
         min_ff    <= min_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      gain_ff  <= gain_in;
      red_ff   <= red_in_nx;
      green_ff <= green_in_nx;
      blue_ff  <= blue_in_nx;
      white_ff <= white_in_nx;
   end

   assign red_out   = red_ff;
   assign green_out = green_ff;
   assign blue_out  = blue_ff;
   assign white_out = white_ff;

endmodule

`default_nettype wire

FILE: src/ble_ctrl.sv
// Controller: handshakes, gain recompute sequence and divider step count.
// Depends on ble_pkg; commands ble_datapath through ble_pkg::cmd_type.
`default_nettype none

module ble_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_opcode,
   output      logic             req_ready,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire ble_pkg::sts_type sts,
   output      ble_pkg::cmd_type cmd
);

   ble_pkg::state_type           state_ff, state_in;
   logic [ble_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         gain_ok_ff, gain_ok_in;
   logic                         dirty_ff, dirty_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic req_fire;
   logic tick_fire;
   logic pixel_fire;
   logic csr_fire;
   logic count_end;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid;
   assign req_ready  = (state_ff == ble_pkg::ST_IDLE) && gain_ok_ff
                       && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign tick_fire  = req_fire && (req_opcode == ble_pkg::OP_TICK);
   assign pixel_fire = req_fire && (req_opcode == ble_pkg::OP_PIXEL);
   assign count_end  = (count_ff == ble_pkg::CNT_W'(ble_pkg::DIV_STEPS));
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dirty_in     = dirty_ff;
      gain_ok_in   = gain_ok_ff;
      rsp_valid_in = pixel_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      cmd            = '0;
      cmd.csr_write  = csr_fire;
      cmd.tick_add   = tick_fire;
      cmd.pixel_load = pixel_fire;

      case (state_ff)
         ble_pkg::ST_IDLE: begin
            if (!gain_ok_ff) begin
               dirty_in = 1'b0;
               count_in = '0;
               if (sts.period_zero) begin
                  state_in = ble_pkg::ST_GAIN;
               end else begin
                  cmd.load_phase = 1'b1;
                  state_in       = ble_pkg::ST_PHASE;
               end
            end
         end
         ble_pkg::ST_PHASE: begin
            if (count_end) begin
               cmd.load_tri = 1'b1;
               count_in     = '0;
               state_in     = ble_pkg::ST_TRI;
            end else begin
               cmd.div_step = 1'b1;
               count_in     = count_ff + 1'b1;
            end
         end
         ble_pkg::ST_TRI: begin
            if (count_end) begin
               state_in = ble_pkg::ST_GAIN;
            end else begin
               cmd.div_step = 1'b1;
               count_in     = count_ff + 1'b1;
            end
         end
         ble_pkg::ST_GAIN: begin
            cmd.load_gain = 1'b1;
            state_in      = ble_pkg::ST_IDLE;
            // a register write during the sequence forces another pass
            if (!dirty_ff) begin
               gain_ok_in = 1'b1;
            end
         end
         default: begin
            state_in = ble_pkg::ST_IDLE;
         end
      endcase

      if (csr_fire && ((state_ff != ble_pkg::ST_IDLE) || !gain_ok_ff)) begin
         dirty_in = 1'b1;
      end
      if (csr_fire || tick_fire) begin
         gain_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ble_pkg::ST_IDLE;
         count_ff     <= '0;
         gain_ok_ff   <= 1'b0;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         gain_ok_ff   <= gain_ok_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for breathing_led_envelope: directed words, random words, CSR sweeps.
// Depends on ble_pkg, ble_req_if, ble_rsp_if, ble_csr_if and the block's RTL.

module tb;

   localparam logic [ble_pkg::CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [ble_pkg::CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WORDS_PER_SET  = 100;
   localparam int FINAL_WORDS    = 80;

   typedef struct packed {
      logic                       opcode;
      logic [ble_pkg::BEAT_W-1:0] beat_count;
      logic [ble_pkg::CHAN_W-1:0] red_in;
      logic [ble_pkg::CHAN_W-1:0] green_in;
      logic [ble_pkg::CHAN_W-1:0] blue_in;
      logic [ble_pkg::CHAN_W-1:0] white_in;
   } req_word_type;

   typedef struct packed {
      logic [ble_pkg::CHAN_W-1:0] red_out;
      logic [ble_pkg::CHAN_W-1:0] green_out;
      logic [ble_pkg::CHAN_W-1:0] blue_out;
      logic [ble_pkg::CHAN_W-1:0] white_out;
   } rgbw_type;

   typedef struct {
      req_word_type word;
      bit           typed;
      rgbw_type     result;
   } dir_row_type;

   typedef struct packed {
      logic [ble_pkg::CSR_DATA_W-1:0] period_data;
      logic [ble_pkg::CSR_DATA_W-1:0] level_data;
   } csr_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ble_req_if req_chan ();
   ble_rsp_if rsp_chan ();
   ble_csr_if csr_chan ();

   breathing_led_envelope i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // running copy of the block's registers and beat total
   bit [ble_pkg::PERIOD_W-1:0] period_q = 16'd1000;
   bit [ble_pkg::LEVEL_W-1:0]  level_q  = '0;
   bit [ble_pkg::TOTAL_W-1:0]  beats_q  = '0;

   rgbw_type pending_pixels [$];
   int       mismatches = 0;
   bit       idle_on    = 1'b1;
   int       quiet_cycles = 0;
   rgbw_type want;

   // reset state: trough at total 0, peak at total 50, trough again at 100, midway at 125
   localparam int DIR_ROWS = 16;
   dir_row_type dir_table [DIR_ROWS] = '{
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd0}},
      '{'{ble_pkg::OP_TICK,  16'd50,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'd255, 8'd128, 8'd1,   8'd0},   1'b1,
        '{8'd255, 8'd128, 8'd1, 8'd0}},
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'd0,   8'd255, 8'd0,   8'd255}, 1'b1,
        '{8'd0, 8'd255, 8'd0, 8'd255}},
      '{'{ble_pkg::OP_TICK,  16'd50,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd0}},
      '{'{ble_pkg::OP_TICK,  16'd25,   8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'd255, 8'd1,   8'd3,   8'd0},   1'b1,
        '{8'd128, 8'd1, 8'd2, 8'd0}},
      '{'{ble_pkg::OP_TICK,  16'hFFFF, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'h5A,  8'hA5,  8'hFF,  8'h01},  1'b0, '0},
      '{'{ble_pkg::OP_TICK,  16'd0,    8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'h80,  8'h7F,  8'h01,  8'hFE},  1'b0, '0},
      // colour on a tick and beats on a pixel must both be dropped
      '{'{ble_pkg::OP_TICK,  16'h1234, 8'hFF,  8'hFF,  8'hFF,  8'hFF},  1'b0, '0},
      '{'{ble_pkg::OP_PIXEL, 16'hFFFF, 8'hC3,  8'h3C,  8'h99,  8'h66},  1'b0, '0},
      '{'{ble_pkg::OP_TICK,  16'h8000, 8'd0,   8'd0,   8'd0,   8'd0},   1'b0, '0},
      '{'{ble_pkg::OP_PIXEL, 16'd0,    8'd0,   8'd0,   8'd0,   8'd0},   1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd0}}
   };

   // zero period, level above full, and a period write with the spare data bit set
   localparam int NUM_PRESETS = 6;
   csr_pair_type presets [NUM_PRESETS] = '{
      '{17'd1,       17'd65536},
      '{17'd65535,   17'd0},
      '{17'd0,       17'd20000},
      '{17'd3,       17'd131071},
      '{17'h1_0007,  17'd65535},
      '{17'd1000,    17'd1}
   };

   function automatic rgbw_type scaled_pixel(req_word_type w);
      bit [63:0] lvl;
      bit [63:0] prd;
      bit [63:0] ph;
      bit [63:0] num;
      bit [63:0] ramp;
      bit [63:0] gain;
      rgbw_type  px;
      lvl  = (level_q > ble_pkg::Q_ONE) ? 64'(ble_pkg::Q_ONE) : 64'(level_q);
      prd  = 64'(period_q);
      ramp = '0;
      if (prd != 0) begin
         ph   = ((64'(ble_pkg::BEAT_MS) * 64'(beats_q)) & 64'hFFFF_FFFF) % prd;
         num  = (64'd2 * ph <= prd) ? ph : prd - ph;
         ramp = (64'd4 * num * 64'(ble_pkg::Q_ONE) + prd) / (64'd2 * prd);
         if (ramp > 64'(ble_pkg::Q_ONE))
            ramp = 64'(ble_pkg::Q_ONE);
      end
      gain = (ramp * (64'(ble_pkg::Q_ONE) - lvl) + lvl * 64'(ble_pkg::Q_ONE)
              + 64'(ble_pkg::ROUND_HALF)) >> 16;
      px.red_out   = 8'((64'(w.red_in)   * gain + 64'(ble_pkg::ROUND_HALF)) >> 16);
      px.green_out = 8'((64'(w.green_in) * gain + 64'(ble_pkg::ROUND_HALF)) >> 16);
      px.blue_out  = 8'((64'(w.blue_in)  * gain + 64'(ble_pkg::ROUND_HALF)) >> 16);
      px.white_out = 8'((64'(w.white_in) * gain + 64'(ble_pkg::ROUND_HALF)) >> 16);
      return px;
   endfunction

   task automatic send_word(input req_word_type w, input bit typed, input rgbw_type typed_px);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= w.opcode;
      req_chan.beat_count <= w.beat_count;
      req_chan.red_in     <= w.red_in;
      req_chan.green_in   <= w.green_in;
      req_chan.blue_in    <= w.blue_in;
      req_chan.white_in   <= w.white_in;
      do @(posedge clock); while (!req_chan.ready);
      if (w.opcode == ble_pkg::OP_TICK) begin
         // a zero period freezes the beat total
         if (period_q != 0)
            beats_q += 32'(w.beat_count);
      end else begin
         pending_pixels.push_back(typed ? typed_px : scaled_pixel(w));
      end
   endtask

   // drop valid, wait out every pixel, then let a tick's recompute finish
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ble_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [ble_pkg::CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         ble_pkg::REG_PERIOD_MS: period_q = data[ble_pkg::PERIOD_W-1:0];
         ble_pkg::REG_MIN_LEVEL: level_q  = data;
         default: ;
      endcase
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random stall bursts while idling is on
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = $urandom_range(0, 9);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: pixel word with none pending: expected none, actual %h", $time,
                     {rsp_chan.red_out, rsp_chan.green_out, rsp_chan.blue_out,
                      rsp_chan.white_out});
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_chan.red_out !== want.red_out) begin
               $display("%0t: red_out expected %0d actual %0d", $time, want.red_out,
                        rsp_chan.red_out);
               mismatches++;
            end
            if (rsp_chan.green_out !== want.green_out) begin
               $display("%0t: green_out expected %0d actual %0d", $time, want.green_out,
                        rsp_chan.green_out);
               mismatches++;
            end
            if (rsp_chan.blue_out !== want.blue_out) begin
               $display("%0t: blue_out expected %0d actual %0d", $time, want.blue_out,
                        rsp_chan.blue_out);
               mismatches++;
            end
            if (rsp_chan.white_out !== want.white_out) begin
               $display("%0t: white_out expected %0d actual %0d", $time, want.white_out,
                        rsp_chan.white_out);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_word_type                   w;
      logic [ble_pkg::CSR_DATA_W-1:0] pd;
      logic [ble_pkg::CSR_DATA_W-1:0] lv;
      req_chan.valid      <= 1'b0;
      req_chan.opcode     <= ble_pkg::OP_TICK;
      req_chan.beat_count <= '0;
      req_chan.red_in     <= '0;
      req_chan.green_in   <= '0;
      req_chan.blue_in    <= '0;
      req_chan.white_in   <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= ble_pkg::REG_PERIOD_MS;
      csr_chan.data       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[k])
         send_word(dir_table[k].word, dir_table[k].typed, dir_table[k].result);

      for (int s = 0; s < NUM_PRESETS + 2; s++) begin
         settle();
         if (s < NUM_PRESETS) begin
            pd = presets[s].period_data;
            lv = presets[s].level_data;
         end else begin
            pd = {1'($urandom), 16'($urandom_range(1, 65535))};
            lv = 17'($urandom_range(0, 65536));
         end
         write_reg(ble_pkg::REG_PERIOD_MS, pd);
         write_reg(ble_pkg::REG_MIN_LEVEL, lv);
         // spare indexes must leave both registers alone
         write_reg((s % 2) ? REG_SPARE_3 : REG_SPARE_2, 17'($urandom));
         idle_on = (s % 3 != 2);
         for (int i = 0; i < WORDS_PER_SET; i++) begin
            w = req_word_type'(49'({$urandom, $urandom}));
            w.opcode = ($urandom_range(0, 9) < 7) ? ble_pkg::OP_PIXEL : ble_pkg::OP_TICK;
            case ($urandom_range(0, 3))
               0: w.beat_count = 16'($urandom_range(0, 15));
               1: w.beat_count = 16'hFFFF;
               default: w.beat_count = 16'($urandom);
            endcase
            send_word(w, 1'b0, '0);
         end
      end

      // last stretch without idling: full ticks between back-to-back pixel runs
      settle();
      write_reg(ble_pkg::REG_PERIOD_MS, 17'd997);
      write_reg(ble_pkg::REG_MIN_LEVEL, 17'h4000);
      idle_on = 1'b0;
      for (int i = 0; i < FINAL_WORDS; i++) begin
         w = req_word_type'(49'({$urandom, $urandom}));
         if (i % 4 == 0) begin
            w.opcode     = ble_pkg::OP_TICK;
            w.beat_count = 16'hFFFF;
         end else begin
            w.opcode = ble_pkg::OP_PIXEL;
         end
         send_word(w, 1'b0, '0);
      end

      settle();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: breathing_led_envelope.f
src/ble_pkg.sv
src/ble_req_if.sv
src/ble_rsp_if.sv
src/ble_csr_if.sv
src/ble_datapath.sv
src/ble_ctrl.sv
src/breathing_led_envelope.sv
tb/sv/tb.sv
